>>> sv/bldc_pkg.sv
// ----------------------------------------------------------------------------
// bldc_pkg
// Shared types, constants and helper functions of the commutation and
// position/speed tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROTOR_OFFSET     = 2'd0,
    CFG_PHASE_LEAD       = 2'd1,
    CFG_COUNTS_PER_REV   = 2'd2,
    CFG_FINE_SPEED_SCALE = 2'd3
  } cfg_reg_e;

  // Event codes
  typedef enum logic [1:0] {
    OP_HALL    = 2'd0,
    OP_ENC     = 2'd1,
    OP_RESTART = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // Saturation limits
  localparam logic [29:0] FINE_RATE_MAX   = 30'h3FFF_FFFF;
  localparam logic [19:0] COARSE_RATE_MAX = 20'd1000000;
  localparam logic [9:0]  POS_MAX         = 10'd1023;
  localparam logic [7:0]  PEND_MAX        = 8'd255;
  localparam logic [31:0] TOTAL_MAX       = 32'hFFFF_FFFF;

  // Register reset values
  localparam logic [2:0]  ROTOR_OFFSET_RST     = 3'd0;
  localparam logic [2:0]  PHASE_LEAD_RST       = 3'sd2;
  localparam logic [9:0]  COUNTS_PER_REV_RST   = 10'd117;
  localparam logic [19:0] FINE_SPEED_SCALE_RST = 20'd8547;

  // Divider: 36-bit dividend (count product in Q8, or rate limit), 32-bit divisor
  localparam int unsigned DIV_N_W     = 36;
  localparam int unsigned DIV_D_W     = 32;
  localparam int unsigned DIV_STEPS   = DIV_N_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  // Gate pattern per drive state, rotor state per hall code
  localparam logic [5:0] GATE_OF_DRIVE [8] = '{
    6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
  };
  localparam logic [2:0] ROTOR_OF_HALL [8] = '{
    3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
  };

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input item
    logic exec;     // apply the event to the tracker state
    logic step;     // one divider iteration
    logic finish;   // write the quotient to its rate register
    logic load;     // copy state into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // event needs a division (valid during exec)
    logic div_last;  // divider is on its last iteration
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WB,
    ST_LOAD
  } ctrl_state_e;

  // Value below 24 reduced mod 6
  function automatic logic [2:0] mod6(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd12) r = r - 5'd12;
    if (r >= 5'd6)  r = r - 5'd6;
    return r[2:0];
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TOTAL_MAX : s[31:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/bldc_ctrl.sv
// ----------------------------------------------------------------------------
// bldc_ctrl
// Sequencer: accept, apply event, divide and write back if needed, load result.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bldc_pkg::dp_cmd_t      cmd_o,
  input  wire bldc_pkg::dp_sts_t sts_i
);
  import bldc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_div ? ST_DIV : ST_LOAD;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) state_d = ST_WB;
      end
      ST_WB: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/bldc_dp.sv
// ----------------------------------------------------------------------------
// bldc_dp
// Tracker state, configuration registers, shared restoring divider and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bldc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [bldc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic [1:0]                           op_i,
  input  wire logic [2:0]                           hall_bits_i,
  input  wire logic                                 enc_a_i,
  input  wire logic                                 enc_b_i,
  input  wire logic [31:0]                          time_us_i,
  input  wire bldc_pkg::dp_cmd_t                    cmd_i,
  output bldc_pkg::dp_sts_t                         sts_o,
  output logic [5:0]                                gate_pattern_o,
  output logic [9:0]                                rotor_counts_o,
  output logic [31:0]                               fine_distance_o,
  output logic [31:0]                               coarse_distance_o,
  output logic [29:0]                               fine_speed_o,
  output logic [19:0]                               coarse_speed_o
);
  import bldc_pkg::*;

  // Configuration
  logic [2:0]  rotor_offset_q;
  logic [2:0]  phase_lead_q;
  logic [9:0]  counts_per_rev_q;
  logic [19:0] fine_speed_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_offset_q     <= ROTOR_OFFSET_RST;
      phase_lead_q       <= PHASE_LEAD_RST;
      counts_per_rev_q   <= COUNTS_PER_REV_RST;
      fine_speed_scale_q <= FINE_SPEED_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ROTOR_OFFSET:     rotor_offset_q     <= cfg_data_i[2:0];
        CFG_PHASE_LEAD:       phase_lead_q       <= cfg_data_i[2:0];
        CFG_COUNTS_PER_REV:   counts_per_rev_q   <= cfg_data_i[9:0];
        CFG_FINE_SPEED_SCALE: fine_speed_scale_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // Captured item
  op_e         op_q;
  logic [2:0]  hall_q;
  logic        enc_a_q, enc_b_q;
  logic [31:0] t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      hall_q  <= hall_bits_i;
      enc_a_q <= enc_a_i;
      enc_b_q <= enc_b_i;
      t_q     <= time_us_i;
    end
  end

  // Tracker state
  logic [5:0]  drive_q, drive_d;
  logic [9:0]  pos_q, pos_d;
  logic [31:0] fine_tot_q, fine_tot_d;
  logic [31:0] coarse_tot_q, coarse_tot_d;
  logic        home_q, home_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] fine_last_q, fine_last_d;
  logic [31:0] coarse_last_q, coarse_last_d;
  logic        fine_rst_q, fine_rst_d;
  logic        coarse_rst_q, coarse_rst_d;
  logic [29:0] fine_rate_q, fine_rate_d;
  logic [19:0] coarse_rate_q, coarse_rate_d;

  // Divider
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 tgt_fine_q, tgt_fine_d;
  logic [DIV_D_W+1:0]   trial;
  logic                 trial_ge;

  // Event decode
  logic [2:0]  rs;
  logic [5:0]  m;
  logic [7:0]  pend_inc;
  logic [27:0] prod;
  logic [31:0] dt_fine, dt_coarse;

  assign rs        = ROTOR_OF_HALL[hall_q];
  assign m         = {3'b0, rs} + 6'd12 - {3'b0, rotor_offset_q}
                     + {{3{phase_lead_q[2]}}, phase_lead_q};
  assign pend_inc  = (pend_q < PEND_MAX) ? pend_q + 8'd1 : PEND_MAX;
  assign prod      = pend_inc * fine_speed_scale_q;
  assign dt_fine   = t_q - fine_last_q;
  assign dt_coarse = t_q - coarse_last_q;

  assign trial    = {1'b0, rem_q, quo_q[DIV_N_W-1]} - {2'b0, dvs_q};
  assign trial_ge = !trial[DIV_D_W+1];

  always_comb begin
    drive_d       = drive_q;
    pos_d         = pos_q;
    fine_tot_d    = fine_tot_q;
    coarse_tot_d  = coarse_tot_q;
    home_d        = home_q;
    pend_d        = pend_q;
    fine_last_d   = fine_last_q;
    coarse_last_d = coarse_last_q;
    fine_rst_d    = fine_rst_q;
    coarse_rst_d  = coarse_rst_q;
    fine_rate_d   = fine_rate_q;
    coarse_rate_d = coarse_rate_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    dvs_d         = dvs_q;
    cnt_d         = cnt_q;
    tgt_fine_d    = tgt_fine_q;
    sts_o         = '0;

    if (cmd_i.exec) begin
      unique case (op_q)
        OP_HALL: begin
          drive_d = GATE_OF_DRIVE[mod6(m[4:0])];
          if (rs == 3'd0) begin
            // home crossing
            if (!coarse_rst_q) begin
              if (dt_coarse == '0) begin
                coarse_rate_d = COARSE_RATE_MAX;
              end else begin
                sts_o.need_div = 1'b1;
                rem_d          = '0;
                quo_d          = DIV_N_W'(COARSE_RATE_MAX);
                dvs_d          = dt_coarse;
                cnt_d          = '0;
                tgt_fine_d     = 1'b0;
              end
            end else begin
              coarse_rst_d = 1'b0;
            end
            coarse_last_d = t_q;
            if (!home_q) begin
              coarse_tot_d = sat_add32(coarse_tot_q, {22'b0, pos_q});
              home_d       = 1'b1;
            end else begin
              coarse_tot_d = sat_add32(coarse_tot_q, {22'b0, counts_per_rev_q});
              fine_tot_d   = coarse_tot_d;
            end
            pos_d = '0;
          end
        end
        OP_ENC: begin
          if (!enc_a_q && !enc_b_q) begin
            pend_d     = pend_inc;
            pos_d      = (pos_q < POS_MAX) ? pos_q + 10'd1 : POS_MAX;
            fine_tot_d = sat_add32(fine_tot_q, 32'd1);
            if (!fine_rst_q) begin
              if (prod == '0) begin
                fine_rate_d = '0;
              end else if (dt_fine == '0) begin
                fine_rate_d = FINE_RATE_MAX;
              end else begin
                sts_o.need_div = 1'b1;
                rem_d          = '0;
                quo_d          = {prod, 8'b0};  // Q8
                dvs_d          = dt_fine;
                cnt_d          = '0;
                tgt_fine_d     = 1'b1;
              end
              pend_d = '0;
            end else begin
              fine_rst_d = 1'b0;
            end
            fine_last_d = t_q;
          end
        end
        OP_RESTART: begin
          fine_rst_d   = 1'b1;
          coarse_rst_d = 1'b1;
        end
        OP_CLEAR: begin
          fine_tot_d   = '0;
          coarse_tot_d = '0;
          home_d       = 1'b0;
        end
        default: ;
      endcase
    end

    if (cmd_i.step) begin
      rem_d = trial_ge ? trial[DIV_D_W-1:0] : {rem_q[DIV_D_W-2:0], quo_q[DIV_N_W-1]};
      quo_d = {quo_q[DIV_N_W-2:0], trial_ge};
      cnt_d = cnt_q + DIV_CNT_W'(1);
    end
    sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

    if (cmd_i.finish) begin
      if (tgt_fine_q) begin
        fine_rate_d = (quo_q[DIV_N_W-1:30] != '0) ? FINE_RATE_MAX : quo_q[29:0];
      end else begin
        coarse_rate_d = quo_q[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q       <= '0;
      pos_q         <= '0;
      fine_tot_q    <= '0;
      coarse_tot_q  <= '0;
      home_q        <= 1'b0;
      pend_q        <= '0;
      fine_last_q   <= '0;
      coarse_last_q <= '0;
      fine_rst_q    <= 1'b0;
      coarse_rst_q  <= 1'b0;
      fine_rate_q   <= '0;
      coarse_rate_q <= '0;
      cnt_q         <= '0;
    end else begin
      drive_q       <= drive_d;
      pos_q         <= pos_d;
      fine_tot_q    <= fine_tot_d;
      coarse_tot_q  <= coarse_tot_d;
      home_q        <= home_d;
      pend_q        <= pend_d;
      fine_last_q   <= fine_last_d;
      coarse_last_q <= coarse_last_d;
      fine_rst_q    <= fine_rst_d;
      coarse_rst_q  <= coarse_rst_d;
      fine_rate_q   <= fine_rate_d;
      coarse_rate_q <= coarse_rate_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    tgt_fine_q <= tgt_fine_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gate_pattern_o    <= drive_q;
      rotor_counts_o    <= pos_q;
      fine_distance_o   <= fine_tot_q;
      coarse_distance_o <= coarse_tot_q;
      fine_speed_o      <= fine_rate_q;
      coarse_speed_o    <= coarse_rate_q;
    end
  end

endmodule

`default_nettype wire

>>> sv/bldc_commutation_position_speed_tracker.sv
// ----------------------------------------------------------------------------
// bldc_commutation_position_speed_tracker
// Hall commutation with encoder position, distance and speed tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one timestamped event item:
//   hall edge, encoder edge, timer restart or distance clear. Every item
//   yields exactly one result item on the output channel
//   (out_valid_o/out_ready_i) holding gate pattern, position, both
//   distances and both speeds after the event.
//   Sequence after accept: exec, then, when a speed measurement divides,
//   the divider (36 restoring iterations) and write-back, then load into
//   the output register. One item is in flight at a time: the next item
//   is accepted only after the result is loaded; the shared divider
//   delivers one bit per cycle.
//   Stall: the result sits in an output register; the next item is
//   accepted while it waits, and that item's result is held back until the
//   register is taken.
//   Reset: rst_ni (async, low) clears all tracker state (drive: gates off),
//   and loads register defaults (offset 0, lead 2, 117 counts/rev, scale 8547).
//   Configuration writes (cfg_we_i) are taken in the cycle they appear and
//   are meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_commutation_position_speed_tracker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [bldc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [bldc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // event item
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       op_i,
  input  wire logic [2:0]                       hall_bits_i,
  input  wire logic                             enc_a_i,
  input  wire logic                             enc_b_i,
  input  wire logic [31:0]                      time_us_i,
  // result item
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [5:0]                            gate_pattern_o,
  output logic [9:0]                            rotor_counts_o,
  output logic [31:0]                           fine_distance_o,
  output logic [31:0]                           coarse_distance_o,
  output logic [29:0]                           fine_speed_o,
  output logic [19:0]                           coarse_speed_o
);
  import bldc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: handshakes and command timing
  bldc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // state, config, divider, output register
  bldc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .hall_bits_i       (hall_bits_i),
    .enc_a_i           (enc_a_i),
    .enc_b_i           (enc_b_i),
    .time_us_i         (time_us_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .gate_pattern_o    (gate_pattern_o),
    .rotor_counts_o    (rotor_counts_o),
    .fine_distance_o   (fine_distance_o),
    .coarse_distance_o (coarse_distance_o),
    .fine_speed_o      (fine_speed_o),
    .coarse_speed_o    (coarse_speed_o)
  );

endmodule

`default_nettype wire

>>> sv/bldc_chk.sv
// ----------------------------------------------------------------------------
// bldc_chk
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             cfg_we_i,
  input wire logic [bldc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input wire logic [bldc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic [1:0]                       op_i,
  input wire logic [2:0]                       hall_bits_i,
  input wire logic                             enc_a_i,
  input wire logic                             enc_b_i,
  input wire logic [31:0]                      time_us_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [5:0]                       gate_pattern_o,
  input wire logic [9:0]                       rotor_counts_o,
  input wire logic [31:0]                      fine_distance_o,
  input wire logic [31:0]                      coarse_distance_o,
  input wire logic [29:0]                      fine_speed_o,
  input wire logic [19:0]                      coarse_speed_o
);
  import bldc_pkg::*;

  // busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready_o high right after an accepted item");

  // a new result only shows up while an item is in flight
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without an item in flight");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(gate_pattern_o)
      && $stable(fine_distance_o) && $stable(fine_speed_o)
      && $stable(coarse_speed_o)))
    else $error("stalled result changed");

  // coarse speed never above its limit, gates always a legal pair or off
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((coarse_speed_o <= COARSE_RATE_MAX)
      && (($countones(gate_pattern_o) == 2) || (gate_pattern_o == 6'h00))))
    else $error("result field out of range");

endmodule

bind bldc_commutation_position_speed_tracker bldc_chk u_bldc_chk (.*);

`default_nettype wire
